// ===== rtl/soc_pkg.sv =====
// soc_pkg: shared types, constants and arithmetic helpers of the spherical orbit camera
// no dependencies; used by every module under rtl

package soc_pkg;

    localparam int RADIUS_W = 23;
    localparam int ANGLE_W  = 16;
    localparam int COORD_W  = 24;
    localparam int TDATA_IN_W  = 128;
    localparam int TDATA_OUT_W = 144;

    localparam int SINCOS_STAGES = 9;
    localparam int SCALE_STAGES  = 4;
    localparam int PIPE_STAGES   = SINCOS_STAGES + SCALE_STAGES;
    localparam int TARGET_DEPTH  = PIPE_STAGES - 1;

    localparam int TURN_UNITS       = 23040;
    localparam int TWO_TURNS        = 2 * TURN_UNITS;
    localparam int QUARTER_UNITS    = 5760;
    localparam int EIGHTH_UNITS     = 2880;
    localparam int RAD_PER_UNIT_Q30 = 292818;

    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [61:0] Q30_HALF = 62'h0000_0000_2000_0000;

    // floor(x / k) = (x * RECIP) >> SHIFT, exact for x below 2^30
    localparam logic [30:0] RECIP_42 = 31'd1636178018;
    localparam int          SHIFT_42 = 36;
    localparam logic [30:0] RECIP_20 = 31'd1717986919;
    localparam int          SHIFT_20 = 35;
    localparam logic [30:0] RECIP_6  = 31'd1431655766;
    localparam int          SHIFT_6  = 33;
    localparam logic [30:0] RECIP_56 = 31'd1227133514;
    localparam int          SHIFT_56 = 36;
    localparam logic [30:0] RECIP_30 = 31'd1145324613;
    localparam int          SHIFT_30 = 35;
    localparam logic [30:0] RECIP_12 = 31'd1431655766;
    localparam int          SHIFT_12 = 34;

    localparam logic signed [24:0] COORD_MAX = 25'sd8388607;
    localparam logic signed [24:0] COORD_MIN = -25'sd8388608;

    typedef logic [30:0] t_q30;
    typedef logic [RADIUS_W-1:0] t_mag;
    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_q30 sin_mag;
        logic sin_neg;
        t_q30 cos_mag;
        logic cos_neg;
    } t_trig;

    typedef struct packed {
        logic neg;
        t_mag mag;
    } t_smag;

    typedef struct packed {
        t_coord z;
        t_coord y;
        t_coord x;
    } t_point;

    typedef struct packed {
        t_point up;
        t_point eye;
    } t_result;

    typedef struct packed {
        logic                       pad;
        t_coord                     target_z;
        t_coord                     target_y;
        t_coord                     target_x;
        logic signed [ANGLE_W-1:0]  azimuth_angle;
        logic signed [ANGLE_W-1:0]  elevation_angle;
        logic [RADIUS_W-1:0]        radius;
    } t_in;

    // q30 product rounded half up
    function automatic t_q30 q30_mul(t_q30 a, t_q30 b);
        logic [61:0] p;
        p = 62'(a) * 62'(b) + Q30_HALF;
        return p[60:30];
    endfunction

    function automatic t_q30 div_const(t_q30 x, t_q30 recip, int unsigned sh);
        logic [61:0] p;
        p = 62'(x) * 62'(recip);
        return t_q30'(p >> sh);
    endfunction

    function automatic t_coord to_coord(t_smag v);
        t_coord m;
        m = t_coord'({1'b0, v.mag});
        return v.neg ? -m : m;
    endfunction

    function automatic t_coord sat_coord(logic signed [24:0] v);
        t_coord r;
        if (v > COORD_MAX) begin
            r = t_coord'(COORD_MAX);
        end else if (v < COORD_MIN) begin
            r = t_coord'(COORD_MIN);
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/spherical_orbit_camera.sv =====
// spherical_orbit_camera: eye point and up vector from radius, elevation, azimuth and look-at
// one item per cycle sustained while the output transfer does not wait
// the 13 register stages (9 sine/cosine, 4 scale and sum) lie between input transfer and output valid
// a full pipeline stalls only while the output transfer waits; empty stages keep filling
// synchronous active-low reset clears the stage valid bits only
// depends on soc_pkg, soc_pipe_ctrl, soc_delay, soc_sincos, soc_scale

module spherical_orbit_camera (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // radius, elevation_angle, azimuth_angle, target_x, target_y, target_z, one zero pad bit
    input  logic [soc_pkg::TDATA_IN_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // eye_x, eye_y, eye_z, up_x, up_y, up_z
    output logic [soc_pkg::TDATA_OUT_W-1:0]     m_axis_tdata
);

    soc_pkg::t_in                         w_in;
    logic [soc_pkg::PIPE_STAGES-1:0]      w_en;
    soc_pkg::t_trig                       w_elev;
    soc_pkg::t_trig                       w_azim;
    soc_pkg::t_mag                        w_radius;
    soc_pkg::t_point                      w_target_in;
    soc_pkg::t_point                      w_target;
    soc_pkg::t_result                     w_result;

    assign w_in = soc_pkg::t_in'(s_axis_tdata);

    assign w_target_in.x = w_in.target_x;
    assign w_target_in.y = w_in.target_y;
    assign w_target_in.z = w_in.target_z;

    soc_pipe_ctrl #(
        .STAGES (soc_pkg::PIPE_STAGES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_en    (w_en)
    );

    soc_sincos u_elev (
        .i_clk   (i_clk),
        .i_en    (w_en[soc_pkg::SINCOS_STAGES-1:0]),
        .i_angle (w_in.elevation_angle),
        .o_trig  (w_elev)
    );

    soc_sincos u_azim (
        .i_clk   (i_clk),
        .i_en    (w_en[soc_pkg::SINCOS_STAGES-1:0]),
        .i_angle (w_in.azimuth_angle),
        .o_trig  (w_azim)
    );

    soc_delay #(
        .WIDTH (soc_pkg::RADIUS_W),
        .DEPTH (soc_pkg::SINCOS_STAGES)
    ) u_radius_dly (
        .i_clk  (i_clk),
        .i_en   (w_en[soc_pkg::SINCOS_STAGES-1:0]),
        .i_data (w_in.radius),
        .o_data (w_radius)
    );

    soc_delay #(
        .WIDTH (3 * soc_pkg::COORD_W),
        .DEPTH (soc_pkg::TARGET_DEPTH)
    ) u_target_dly (
        .i_clk  (i_clk),
        .i_en   (w_en[soc_pkg::TARGET_DEPTH-1:0]),
        .i_data (w_target_in),
        .o_data (w_target)
    );

    soc_scale u_scale (
        .i_clk    (i_clk),
        .i_en     (w_en[soc_pkg::PIPE_STAGES-1:soc_pkg::SINCOS_STAGES]),
        .i_elev   (w_elev),
        .i_azim   (w_azim),
        .i_radius (w_radius),
        .i_target (w_target),
        .o_result (w_result)
    );

    assign m_axis_tdata = w_result;

endmodule

// ===== rtl/soc_pipe_ctrl.sv =====
// soc_pipe_ctrl: valid bits and per-stage load enables of the pipeline
// a stage loads when it is empty or the stage after it loads; depends on soc_pkg

module soc_pipe_ctrl #(
    parameter int STAGES = soc_pkg::PIPE_STAGES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [STAGES-1:0] o_en
);

    logic [STAGES-1:0] r_valid;
    logic [STAGES-1:0] n_valid;
    logic [STAGES-1:0] w_en;

    always_comb begin
        logic [STAGES-1:0] mask;
        for (int k = 0; k < STAGES; k++) begin
            mask    = {STAGES{1'b1}} << k;
            w_en[k] = i_ready || ((r_valid & mask) != mask);
        end
        n_valid[0] = w_en[0] ? i_valid : r_valid[0];
        for (int k = 1; k < STAGES; k++) begin
            n_valid[k] = w_en[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_en    = w_en;
    assign o_ready = w_en[0];
    assign o_valid = r_valid[STAGES-1];

endmodule

// ===== rtl/soc_delay.sv =====
// soc_delay: enabled shift line that keeps side data in step with the pipeline
// one register per stage, loaded with that stage's enable; depends on soc_pkg

module soc_delay #(
    parameter int WIDTH = soc_pkg::RADIUS_W,
    parameter int DEPTH = soc_pkg::SINCOS_STAGES
) (
    input  logic             i_clk,
    input  logic [DEPTH-1:0] i_en,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_line[0] <= i_data;
        end
        for (int k = 1; k < DEPTH; k++) begin
            if (i_en[k]) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_data = r_line[DEPTH-1];

endmodule

// ===== rtl/soc_sincos.sv =====
// soc_sincos: nine-stage sine and cosine of one angle in 1/64 degree units
// wrap, octant fold, q30 polynomials, quadrant map to sign and magnitude; depends on soc_pkg

module soc_sincos (
    input  logic                                   i_clk,
    input  logic [soc_pkg::SINCOS_STAGES-1:0]      i_en,
    input  logic signed [soc_pkg::ANGLE_W-1:0]     i_angle,
    output soc_pkg::t_trig                         o_trig
);

    // stage 0: wrap into one turn
    logic [14:0] r_phase;
    logic [14:0] n_phase;
    // stage 1: quadrant and fold
    logic [11:0] r_u;
    logic [11:0] n_u;
    logic [1:0]  n_quad;
    logic        n_swap;
    logic [1:0]  r_quad [1:7];
    logic        r_swap [1:7];
    // stages 2 to 7
    soc_pkg::t_q30 r_x_s2, r_x_s3, r_x_s4, r_x_s5, r_x_s6;
    soc_pkg::t_q30 r_x2;
    soc_pkg::t_q30 r_t1s, r_t1c, r_d20, r_d6_s4, r_d30, r_d12_s4, r_d2_s4;
    soc_pkg::t_q30 r_t2s, r_t2c, r_d6_s5, r_d12_s5, r_d2_s5;
    soc_pkg::t_q30 r_t3s, r_t3c, r_d2_s6;
    soc_pkg::t_q30 r_so, r_co;
    soc_pkg::t_trig r_trig;
    soc_pkg::t_trig n_trig;

    always_comb begin
        logic [16:0] lift;
        logic [16:0] once;
        lift = {i_angle[15], i_angle} + 17'(soc_pkg::TWO_TURNS);
        once = (lift >= 17'(soc_pkg::TWO_TURNS)) ? lift - 17'(soc_pkg::TWO_TURNS) : lift;
        n_phase = (once >= 17'(soc_pkg::TURN_UNITS)) ?
                  15'(once - 17'(soc_pkg::TURN_UNITS)) : 15'(once);
    end

    always_comb begin
        logic [12:0] rem;
        if (r_phase >= 15'(3 * soc_pkg::QUARTER_UNITS)) begin
            n_quad = 2'd3;
            rem    = 13'(r_phase - 15'(3 * soc_pkg::QUARTER_UNITS));
        end else if (r_phase >= 15'(2 * soc_pkg::QUARTER_UNITS)) begin
            n_quad = 2'd2;
            rem    = 13'(r_phase - 15'(2 * soc_pkg::QUARTER_UNITS));
        end else if (r_phase >= 15'(soc_pkg::QUARTER_UNITS)) begin
            n_quad = 2'd1;
            rem    = 13'(r_phase - 15'(soc_pkg::QUARTER_UNITS));
        end else begin
            n_quad = 2'd0;
            rem    = 13'(r_phase);
        end
        n_swap = rem > 13'(soc_pkg::EIGHTH_UNITS);
        n_u    = n_swap ? 12'(13'(soc_pkg::QUARTER_UNITS) - rem) : 12'(rem);
    end

    always_comb begin
        logic odd;
        odd            = r_swap[7] ^ r_quad[7][0];
        n_trig.sin_mag = odd ? r_co : r_so;
        n_trig.cos_mag = odd ? r_so : r_co;
        n_trig.sin_neg = r_quad[7][1];
        n_trig.cos_neg = r_quad[7][1] ^ r_quad[7][0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_phase <= n_phase;
        end
        if (i_en[1]) begin
            r_u       <= n_u;
            r_quad[1] <= n_quad;
            r_swap[1] <= n_swap;
        end
        for (int k = 2; k <= 7; k++) begin
            if (i_en[k]) begin
                r_quad[k] <= r_quad[k-1];
                r_swap[k] <= r_swap[k-1];
            end
        end
        if (i_en[2]) begin
            r_x_s2 <= 31'(r_u) * 31'(soc_pkg::RAD_PER_UNIT_Q30);
        end
        if (i_en[3]) begin
            r_x_s3 <= r_x_s2;
            r_x2   <= soc_pkg::q30_mul(r_x_s2, r_x_s2);
        end
        if (i_en[4]) begin
            r_x_s4   <= r_x_s3;
            r_t1s    <= soc_pkg::Q30_ONE -
                        soc_pkg::div_const(r_x2, soc_pkg::RECIP_42, soc_pkg::SHIFT_42);
            r_t1c    <= soc_pkg::Q30_ONE -
                        soc_pkg::div_const(r_x2, soc_pkg::RECIP_56, soc_pkg::SHIFT_56);
            r_d20    <= soc_pkg::div_const(r_x2, soc_pkg::RECIP_20, soc_pkg::SHIFT_20);
            r_d6_s4  <= soc_pkg::div_const(r_x2, soc_pkg::RECIP_6, soc_pkg::SHIFT_6);
            r_d30    <= soc_pkg::div_const(r_x2, soc_pkg::RECIP_30, soc_pkg::SHIFT_30);
            r_d12_s4 <= soc_pkg::div_const(r_x2, soc_pkg::RECIP_12, soc_pkg::SHIFT_12);
            r_d2_s4  <= r_x2 >> 1;
        end
        if (i_en[5]) begin
            r_x_s5   <= r_x_s4;
            r_t2s    <= soc_pkg::Q30_ONE - soc_pkg::q30_mul(r_d20, r_t1s);
            r_t2c    <= soc_pkg::Q30_ONE - soc_pkg::q30_mul(r_d30, r_t1c);
            r_d6_s5  <= r_d6_s4;
            r_d12_s5 <= r_d12_s4;
            r_d2_s5  <= r_d2_s4;
        end
        if (i_en[6]) begin
            r_x_s6  <= r_x_s5;
            r_t3s   <= soc_pkg::Q30_ONE - soc_pkg::q30_mul(r_d6_s5, r_t2s);
            r_t3c   <= soc_pkg::Q30_ONE - soc_pkg::q30_mul(r_d12_s5, r_t2c);
            r_d2_s6 <= r_d2_s5;
        end
        if (i_en[7]) begin
            r_so <= soc_pkg::q30_mul(r_x_s6, r_t3s);
            r_co <= soc_pkg::Q30_ONE - soc_pkg::q30_mul(r_d2_s6, r_t3c);
        end
        if (i_en[8]) begin
            r_trig <= n_trig;
        end
    end

    assign o_trig = r_trig;

endmodule

// ===== rtl/soc_scale.sv =====
// soc_scale: four-stage scaling of the radius by the angle terms and the eye sums
// sign and magnitude products, then signed offsets and saturated sums; depends on soc_pkg

module soc_scale (
    input  logic                                i_clk,
    input  logic [soc_pkg::SCALE_STAGES-1:0]    i_en,
    input  soc_pkg::t_trig                      i_elev,
    input  soc_pkg::t_trig                      i_azim,
    input  soc_pkg::t_mag                       i_radius,
    input  soc_pkg::t_point                     i_target,
    output soc_pkg::t_result                    o_result
);

    soc_pkg::t_smag   r_rs, r_rc;
    soc_pkg::t_trig   r_azim;
    soc_pkg::t_smag   r_ex, r_ey, r_ez, r_ux, r_uy, r_uz;
    soc_pkg::t_point  r_eye_off, r_up_off;
    soc_pkg::t_result r_result;
    soc_pkg::t_result n_result;

    always_comb begin
        n_result.eye.x = soc_pkg::sat_coord(25'(i_target.x) + 25'(r_eye_off.x));
        n_result.eye.y = soc_pkg::sat_coord(25'(i_target.y) + 25'(r_eye_off.y));
        n_result.eye.z = soc_pkg::sat_coord(25'(i_target.z) + 25'(r_eye_off.z));
        n_result.up    = r_up_off;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rs.mag <= soc_pkg::t_mag'(soc_pkg::q30_mul(31'(i_radius), i_elev.sin_mag));
            r_rs.neg <= i_elev.sin_neg;
            r_rc.mag <= soc_pkg::t_mag'(soc_pkg::q30_mul(31'(i_radius), i_elev.cos_mag));
            r_rc.neg <= i_elev.cos_neg;
            r_azim   <= i_azim;
        end
        if (i_en[1]) begin
            r_ex.mag <= soc_pkg::t_mag'(soc_pkg::q30_mul(31'(r_rs.mag), r_azim.cos_mag));
            r_ex.neg <= r_rs.neg ^ r_azim.cos_neg;
            r_ez.mag <= soc_pkg::t_mag'(soc_pkg::q30_mul(31'(r_rs.mag), r_azim.sin_mag));
            r_ez.neg <= r_rs.neg ^ r_azim.sin_neg;
            r_ux.mag <= soc_pkg::t_mag'(soc_pkg::q30_mul(31'(r_rc.mag), r_azim.cos_mag));
            r_ux.neg <= r_rc.neg ^ r_azim.cos_neg;
            r_uz.mag <= soc_pkg::t_mag'(soc_pkg::q30_mul(31'(r_rc.mag), r_azim.sin_mag));
            r_uz.neg <= r_rc.neg ^ r_azim.sin_neg;
            r_ey     <= r_rc;
            r_uy.mag <= r_rs.mag;
            r_uy.neg <= !r_rs.neg;
        end
        if (i_en[2]) begin
            r_eye_off.x <= soc_pkg::to_coord(r_ex);
            r_eye_off.y <= soc_pkg::to_coord(r_ey);
            r_eye_off.z <= soc_pkg::to_coord(r_ez);
            r_up_off.x  <= soc_pkg::to_coord(r_ux);
            r_up_off.y  <= soc_pkg::to_coord(r_uy);
            r_up_off.z  <= soc_pkg::to_coord(r_uz);
        end
        if (i_en[3]) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

// ===== sim/tb_spherical_orbit_camera.sv =====
// tb_spherical_orbit_camera: self-checking testbench of the spherical orbit camera stream block
// predicts eye point and up vector per input transfer and compares each output transfer in order
// depends on soc_pkg and spherical_orbit_camera under rtl

module tb_spherical_orbit_camera;

    localparam int          CLK_HALF     = 5;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES = 2 * soc_pkg::PIPE_STAGES;
    localparam int          RANDOM_ITEMS = 2000;
    localparam int          MAX_WAIT     = 6;
    localparam int          MAX_ANGLE    = soc_pkg::TURN_UNITS;
    localparam longint      Q30_UNIT     = 64'sd1 << 30;
    localparam logic [63:0] Q30_ROUND    = 64'd1 << 29;

    typedef enum int {QUAD_FIRST, QUAD_SECOND, QUAD_THIRD, QUAD_FOURTH} t_quadrant;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // radius, elevation_angle, azimuth_angle, target_x, target_y, target_z, pad
    logic [soc_pkg::TDATA_IN_W-1:0]  s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // eye_x, eye_y, eye_z, up_x, up_y, up_z
    logic [soc_pkg::TDATA_OUT_W-1:0] m_axis_tdata;

    soc_pkg::t_in     camera_in_q[$];
    soc_pkg::t_result eye_up_due[$];
    logic    in_xfer = 1'b0;
    logic    out_xfer = 1'b0;
    logic    in_busy = 1'b0;
    int      in_gap = 0;
    int      out_wait = 0;
    int      sent_n = 0;
    int      got_n = 0;
    int      idle_cycles = 0;
    int      mismatches = 0;

    spherical_orbit_camera i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic logic [63:0] q30_round(input logic [63:0] a, input logic [63:0] b);
        return (a * b + Q30_ROUND) >> 30;
    endfunction

    // polynomial sine and cosine on the first octant, q30
    function automatic void octant_trig(input longint u, output longint s, output longint c);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        x  = 64'(u) * 64'(soc_pkg::RAD_PER_UNIT_Q30);
        x2 = q30_round(x, x);
        t  = Q30_UNIT - x2 / 42;
        t  = Q30_UNIT - q30_round(x2 / 20, t);
        t  = Q30_UNIT - q30_round(x2 / 6, t);
        s  = longint'(q30_round(x, t));
        t  = Q30_UNIT - x2 / 56;
        t  = Q30_UNIT - q30_round(x2 / 30, t);
        t  = Q30_UNIT - q30_round(x2 / 12, t);
        c  = Q30_UNIT - longint'(q30_round(x2 / 2, t));
    endfunction

    function automatic void angle_trig(input logic signed [soc_pkg::ANGLE_W-1:0] raw,
                                       output longint sn, output longint cs);
        longint    a;
        longint    r;
        longint    s;
        longint    c;
        longint    t;
        t_quadrant q;
        a = (longint'(raw) + soc_pkg::TWO_TURNS) % soc_pkg::TURN_UNITS;
        q = t_quadrant'(a / soc_pkg::QUARTER_UNITS);
        r = a % soc_pkg::QUARTER_UNITS;
        if (r <= soc_pkg::EIGHTH_UNITS) begin
            octant_trig(r, s, c);
        end else begin
            octant_trig(soc_pkg::QUARTER_UNITS - r, c, s);
        end
        case (q)
            QUAD_SECOND: begin
                t = s; s = c; c = -t;
            end
            QUAD_THIRD: begin
                s = -s; c = -c;
            end
            QUAD_FOURTH: begin
                t = s; s = -c; c = t;
            end
            default: begin
            end
        endcase
        sn = s;
        cs = c;
    endfunction

    // sign-magnitude scale by a q30 factor, magnitude rounded half up
    function automatic longint scale_q30(input longint v, input longint f);
        logic        neg;
        logic [63:0] mv;
        logic [63:0] mf;
        logic [63:0] m;
        neg = (v < 0) != (f < 0);
        mv  = (v < 0) ? -v : v;
        mf  = (f < 0) ? -f : f;
        m   = (mv * mf + Q30_ROUND) >> 30;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic soc_pkg::t_coord clamp_coord(input longint v);
        if (v > longint'(soc_pkg::COORD_MAX)) begin
            return soc_pkg::t_coord'(soc_pkg::COORD_MAX);
        end
        if (v < longint'(soc_pkg::COORD_MIN)) begin
            return soc_pkg::t_coord'(soc_pkg::COORD_MIN);
        end
        return soc_pkg::t_coord'(v);
    endfunction

    function automatic soc_pkg::t_result predict_eye_up(input soc_pkg::t_in d);
        soc_pkg::t_result r;
        longint  se;
        longint  ce;
        longint  sa;
        longint  ca;
        longint  rs;
        longint  rc;
        angle_trig(d.elevation_angle, se, ce);
        angle_trig(d.azimuth_angle, sa, ca);
        rs       = scale_q30(longint'(d.radius), se);
        rc       = scale_q30(longint'(d.radius), ce);
        r.eye.x  = clamp_coord(longint'(d.target_x) + scale_q30(rs, ca));
        r.eye.y  = clamp_coord(longint'(d.target_y) + rc);
        r.eye.z  = clamp_coord(longint'(d.target_z) + scale_q30(rs, sa));
        r.up.x   = clamp_coord(scale_q30(rc, ca));
        r.up.y   = clamp_coord(-rs);
        r.up.z   = clamp_coord(scale_q30(rc, sa));
        return r;
    endfunction

    function automatic soc_pkg::t_in make_item(input int rad, input int el, input int az,
                                               input int tx, input int ty, input int tz);
        soc_pkg::t_in d;
        d.pad             = 1'b0;
        d.radius          = soc_pkg::t_mag'(rad);
        d.elevation_angle = el[soc_pkg::ANGLE_W-1:0];
        d.azimuth_angle   = az[soc_pkg::ANGLE_W-1:0];
        d.target_x        = soc_pkg::t_coord'(tx);
        d.target_y        = soc_pkg::t_coord'(ty);
        d.target_z        = soc_pkg::t_coord'(tz);
        return d;
    endfunction

    function automatic int random_angle();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0) begin
            // near a quadrant or octant boundary
            return int'($urandom_range(0, 16)) * soc_pkg::EIGHTH_UNITS - soc_pkg::TURN_UNITS
                   + int'($urandom_range(0, 4)) - 2;
        end
        return int'($urandom_range(0, 2 * MAX_ANGLE)) - MAX_ANGLE;
    endfunction

    function automatic int random_coord();
        int pick;
        pick = $urandom_range(0, 4);
        if (pick == 0) begin
            return int'(soc_pkg::COORD_MAX) - int'($urandom_range(0, 65535));
        end
        if (pick == 1) begin
            return int'(soc_pkg::COORD_MIN) + int'($urandom_range(0, 65535));
        end
        return int'(soc_pkg::t_coord'($urandom));
    endfunction

    function automatic int random_radius();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 65535);
            1: return (1 << soc_pkg::RADIUS_W) - 1 - int'($urandom_range(0, 4095));
            default: return $urandom_range(0, (1 << soc_pkg::RADIUS_W) - 1);
        endcase
    endfunction

    function automatic void check_field(input string name, input soc_pkg::t_coord exp_v,
                                        input soc_pkg::t_coord act_v);
        if (exp_v !== act_v) begin
            $error("%s expected %0d actual %0d", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        soc_pkg::t_result exp_r;
        soc_pkg::t_result act_r;
        in_xfer  <= i_rst_n && s_axis_tvalid && s_axis_tready;
        out_xfer <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            act_r = soc_pkg::t_result'(m_axis_tdata);
            if (eye_up_due.size() == 0) begin
                $error("output transfer with no result pending");
                mismatches++;
            end else begin
                exp_r = eye_up_due.pop_front();
                check_field("eye_x", exp_r.eye.x, act_r.eye.x);
                check_field("eye_y", exp_r.eye.y, act_r.eye.y);
                check_field("eye_z", exp_r.eye.z, act_r.eye.z);
                check_field("up_x", exp_r.up.x, act_r.up.x);
                check_field("up_y", exp_r.up.y, act_r.up.y);
                check_field("up_z", exp_r.up.z, act_r.up.z);
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            eye_up_due.push_back(predict_eye_up(soc_pkg::t_in'(s_axis_tdata)));
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else if (i_rst_n) begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_spherical_orbit_camera: errors");
                $finish;
            end
        end
    end

    // input driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_xfer) begin
                in_busy = 1'b0;
                sent_n++;
                in_gap = ((sent_n / 64) % 4 == 3) ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (!in_busy) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (camera_in_q.size() > 0) begin
                    s_axis_tdata <= camera_in_q.pop_front();
                    in_busy = 1'b1;
                end
            end
            s_axis_tvalid <= in_busy;
        end
    end

    // output stall pattern
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_xfer) begin
                got_n++;
                out_wait = ((got_n / 64) % 4 == 1) ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (out_wait > 0) begin
                out_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int mx;
        int qu;
        int eu;
        int tu;
        int cmax;
        int cmin;
        mx   = (1 << soc_pkg::RADIUS_W) - 1;
        qu   = soc_pkg::QUARTER_UNITS;
        eu   = soc_pkg::EIGHTH_UNITS;
        tu   = soc_pkg::TURN_UNITS;
        cmax = int'(soc_pkg::COORD_MAX);
        cmin = int'(soc_pkg::COORD_MIN);
        camera_in_q.push_back(make_item(0, 0, 0, 0, 0, 0));
        camera_in_q.push_back(make_item(mx, 0, 0, 0, 0, 0));
        camera_in_q.push_back(make_item(mx, qu, 0, cmax, 0, 0));
        camera_in_q.push_back(make_item(mx, qu, 2 * qu, cmin, 0, 0));
        camera_in_q.push_back(make_item(mx, -tu, tu, 0, 0, 0));
        camera_in_q.push_back(make_item(mx, tu, -tu, 0, 0, 0));
        camera_in_q.push_back(make_item(mx, eu, eu, 0, 0, 0));
        camera_in_q.push_back(make_item(mx, eu + 1, eu - 1, 0, 0, 0));
        camera_in_q.push_back(make_item(mx, 3 * qu, qu, 0, 0, 0));
        camera_in_q.push_back(make_item(mx, 2 * qu, -qu, 0, cmin, 0));
        camera_in_q.push_back(make_item(mx, 0, 0, 0, cmax, 0));
        camera_in_q.push_back(make_item(1, -1, 1, -1, 1, -1));
        camera_in_q.push_back(make_item(mx, -eu, -eu - 1, 0, 0, 0));
        camera_in_q.push_back(make_item(0, 0, 0, cmax, cmin, cmax));
        camera_in_q.push_back(make_item(0, 0, 0, cmin, cmax, cmin));
        camera_in_q.push_back(make_item(24'h555555, 16'h5555, -21846,
                                        24'h555555, -5592406, 24'h555555));
        camera_in_q.push_back(make_item(24'h2AAAAA, -10923, 16'h2AAA,
                                        -5592406, 24'h555555, -5592406));
        camera_in_q.push_back(make_item(mx, 8640, 14400, 0, 0, cmax));
        camera_in_q.push_back(make_item(mx, -8640, -14400, 0, 0, cmin));
        camera_in_q.push_back(make_item(mx, 4 * qu - 1, 1 - 4 * qu, cmax, cmax, cmax));
        camera_in_q.push_back(make_item(mx, qu + eu, -eu, cmin, cmin, cmin));
        repeat (RANDOM_ITEMS) begin
            camera_in_q.push_back(make_item(random_radius(), random_angle(), random_angle(),
                                            random_coord(), random_coord(), random_coord()));
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (camera_in_q.size() != 0 || in_busy || eye_up_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_spherical_orbit_camera: clean");
        end else begin
            $display("tb_spherical_orbit_camera: errors");
        end
        $finish;
    end

endmodule
